FILE: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared assertion macros for the mosaic filter rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every clock edge outside reset
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// checked on every clock edge, reset included
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

FILE: hw/rtl/lsmf_pkg.sv
// ----------------------------------------------------------------------------
// lsmf_pkg
// types and constants shared by the subpixel mosaic filter modules
// ----------------------------------------------------------------------------
package lsmf_pkg;

  localparam int MAX_ROW_PIXELS = 4096;
  localparam int IDX_W          = $clog2(MAX_ROW_PIXELS);

  localparam int CHAN_W  = 16;
  localparam int PIXEL_W = 4 * CHAN_W;
  localparam int CELL_W  = 6;
  localparam int GAIN_W  = 12;
  localparam int CFG_W   = 12;
  localparam int CMP_W   = CELL_W + 10;

  localparam logic [CELL_W-1:0] CELL_SIZE_RESET = CELL_W'(10);
  localparam logic [GAIN_W-1:0] GAIN_RESET      = GAIN_W'(640);

  // configuration register indexes
  localparam logic CFG_CELL_SIZE = 1'b0;
  localparam logic CFG_GAIN      = 1'b1;

  // front to back queue
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // boost arithmetic: round(v * w * gain / 6400)
  localparam int GW_W         = GAIN_W + 5;
  localparam int PROD_W       = CHAN_W + GW_W;
  localparam int SCALE_SHIFT  = 8;
  localparam int X_W          = PROD_W - SCALE_SHIFT;
  localparam int QX_W         = 21;
  localparam int RECIP_W      = 28;
  localparam int RECIP_SHIFT  = 32;
  localparam int QP_W         = QX_W + RECIP_W;
  localparam logic [PROD_W-1:0]  ROUND_BIAS = PROD_W'(3200);
  localparam logic [X_W-1:0]     SAT_LIMIT  = X_W'(25 * 65536);
  localparam logic [RECIP_W-1:0] RECIP_25   = RECIP_W'(171798692);
  localparam logic [CHAN_W-1:0]  CHAN_MAX   = '1;

  typedef enum logic [1:0] {
    CH_RED,
    CH_GREEN,
    CH_BLUE
  } chan_sel_e;

  typedef enum logic [1:0] {
    W_FULL,
    W_GAP,
    W_CORNER
  } weight_e;

  typedef struct packed {
    logic [CHAN_W-1:0] red_in;
    logic [CHAN_W-1:0] green_in;
    logic [CHAN_W-1:0] blue_in;
    logic [CHAN_W-1:0] alpha_in;
    logic              frame_start;
    logic              row_end;
  } pix_in_t;

  typedef struct packed {
    logic [CHAN_W-1:0] red_out;
    logic [CHAN_W-1:0] green_out;
    logic [CHAN_W-1:0] blue_out;
    logic [CHAN_W-1:0] alpha_out;
    logic              row_end_out;
  } pix_out_t;

  // classification of one pixel in the front
  typedef struct packed {
    chan_sel_e sel;
    weight_e   wt;
    logic      capture;
    logic      row_end;
  } pix_cls_t;

  typedef struct packed {
    logic [CHAN_W-1:0] value;
    logic [CHAN_W-1:0] alpha;
    chan_sel_e         sel;
    weight_e           wt;
    logic              row_end;
  } q_entry_t;

endpackage

FILE: hw/rtl/lsmf_ram.sv
// ----------------------------------------------------------------------------
// lsmf_ram
// generic single port ram with registered read
// ----------------------------------------------------------------------------
module lsmf_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hw/rtl/lsmf_front.sv
// ----------------------------------------------------------------------------
// lsmf_front
// cell phase tracking, sample store access and pixel classification
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lsmf_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [lsmf_pkg::CELL_W-1:0]   cell_size_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  lsmf_pkg::pix_in_t             in_data_i,
  output logic                          push_o,
  input  logic                          full_i,
  output lsmf_pkg::q_entry_t            push_data_o
);
  import lsmf_pkg::*;

  logic [CELL_W-1:0]  col_q, col_d;
  logic [CELL_W-1:0]  row_q, row_d;
  logic [IDX_W-1:0]   idx_q, idx_d;
  logic               f1_valid_q, f1_valid_d;
  pix_cls_t           f1_cls_q, cls;
  logic [PIXEL_W-1:0] f1_pix_q;

  logic               accept;
  logic [CELL_W-1:0]  s, c, r;
  logic [IDX_W-1:0]   idx;
  logic               col_gap, row_gap, is_red, is_green;
  logic [PIXEL_W-1:0] pix_word, rdata, smp;
  logic               ram_we, ram_re;

  assign in_ready_o = !f1_valid_q || !full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign push_o     = f1_valid_q && !full_i;

  // zero size acts as one
  assign s   = (cell_size_i == '0) ? CELL_W'(1) : cell_size_i;
  assign c   = in_data_i.frame_start ? '0 : col_q;
  assign r   = in_data_i.frame_start ? '0 : row_q;
  assign idx = in_data_i.frame_start ? '0 : idx_q;

  assign col_gap  = (CMP_W'(c) * CMP_W'(10)) < CMP_W'(s);
  assign row_gap  = (CMP_W'(r) * CMP_W'(10)) < CMP_W'(s);
  assign is_red   = (CMP_W'(c) * CMP_W'(1000)) < (CMP_W'(s) * CMP_W'(333));
  assign is_green = (CMP_W'(c) * CMP_W'(1000)) < (CMP_W'(s) * CMP_W'(666));

  always_comb begin
    cls.capture = (c == '0) && (r == '0);
    cls.row_end = in_data_i.row_end;
    priority if (is_red) begin
      cls.sel = CH_RED;
    end else if (is_green) begin
      cls.sel = CH_GREEN;
    end else begin
      cls.sel = CH_BLUE;
    end
    priority if (col_gap && row_gap) begin
      cls.wt = W_CORNER;
    end else if (col_gap || row_gap) begin
      cls.wt = W_GAP;
    end else begin
      cls.wt = W_FULL;
    end
  end

  // phase advance after the pixel
  always_comb begin
    col_d = col_q;
    row_d = row_q;
    idx_d = idx_q;
    if (accept) begin
      row_d = r;
      idx_d = idx;
      priority if (in_data_i.row_end) begin
        col_d = '0;
        idx_d = '0;
        row_d = ({1'b0, r} + (CELL_W+1)'(1) >= {1'b0, s}) ? '0 : r + CELL_W'(1);
      end else if ({1'b0, c} + (CELL_W+1)'(1) >= {1'b0, s}) begin
        col_d = '0;
        idx_d = (idx == IDX_W'(MAX_ROW_PIXELS - 1)) ? '0 : idx + IDX_W'(1);
      end else begin
        col_d = c + CELL_W'(1);
      end
    end
  end

  always_comb begin
    f1_valid_d = f1_valid_q;
    if (accept) begin
      f1_valid_d = 1'b1;
    end else if (push_o) begin
      f1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      idx_q      <= '0;
      f1_valid_q <= 1'b0;
    end else begin
      col_q      <= col_d;
      row_q      <= row_d;
      idx_q      <= idx_d;
      f1_valid_q <= f1_valid_d;
    end
  end

  assign pix_word = {in_data_i.alpha_in, in_data_i.blue_in,
                     in_data_i.green_in, in_data_i.red_in};

  always_ff @(posedge clk_i) begin
    if (accept) begin
      f1_cls_q <= cls;
      f1_pix_q <= pix_word;
    end
  end

  // a capture writes its own sample, any other pixel reads the stored one
  assign ram_we = accept && cls.capture;
  assign ram_re = accept && !cls.capture;

  lsmf_ram #(
    .WIDTH(PIXEL_W),
    .DEPTH(MAX_ROW_PIXELS)
  ) u_sample_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .re_i   (ram_re),
    .addr_i (idx),
    .wdata_i(pix_word),
    .rdata_o(rdata)
  );

  assign smp = f1_cls_q.capture ? f1_pix_q : rdata;

  always_comb begin
    push_data_o.alpha   = smp[3*CHAN_W +: CHAN_W];
    push_data_o.sel     = f1_cls_q.sel;
    push_data_o.wt      = f1_cls_q.wt;
    push_data_o.row_end = f1_cls_q.row_end;
    unique case (f1_cls_q.sel)
      CH_RED:   push_data_o.value = smp[0 +: CHAN_W];
      CH_GREEN: push_data_o.value = smp[CHAN_W +: CHAN_W];
      CH_BLUE:  push_data_o.value = smp[2*CHAN_W +: CHAN_W];
      default:  push_data_o.value = '0;
    endcase
  end

  `ASSERT_CLK(a_accept_loads_stage, accept |=> f1_valid_q, "accepted pixel not held in stage")
  `ASSERT_CLK(a_ram_single_access, !(ram_we && ram_re), "sample store written and read together")

endmodule

FILE: hw/rtl/lsmf_queue.sv
// ----------------------------------------------------------------------------
// lsmf_queue
// short fifo between the classifying front and the arithmetic back
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lsmf_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  lsmf_pkg::q_entry_t  data_i,
  output logic                full_o,
  input  logic                pop_i,
  output logic                empty_o,
  output lsmf_pkg::q_entry_t  data_o
);
  import lsmf_pkg::*;

  q_entry_t            mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0]   count_q, count_d;

  assign full_o  = (count_q == QCNT_W'(QUEUE_DEPTH));
  assign empty_o = (count_q == '0);
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + QCNT_W'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  `ASSERT_CLK(a_no_pop_empty, pop_i |-> !empty_o, "pop from empty queue")
  `ASSERT_CLK(a_no_push_full, push_i |-> (!full_o || pop_i), "push into full queue")
  `ASSERT_ALWAYS(a_count_bound, !rst_ni || count_q <= QCNT_W'(QUEUE_DEPTH), "queue overflow")

endmodule

FILE: hw/rtl/lsmf_back.sv
// ----------------------------------------------------------------------------
// lsmf_back
// weight and gain multiply, divide by 6400 with rounding, saturation
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lsmf_back (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [lsmf_pkg::GAIN_W-1:0]  gain_i,
  output logic                         pop_o,
  input  logic                         empty_i,
  input  lsmf_pkg::q_entry_t           data_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output lsmf_pkg::pix_out_t           out_data_o
);
  import lsmf_pkg::*;

  logic              adv;
  logic [GW_W-1:0]   gw;
  logic              b_valid_q;
  logic [PROD_W-1:0] b_prod_q;
  chan_sel_e         b_sel_q;
  logic [CHAN_W-1:0] b_alpha_q;
  logic              b_row_end_q;
  logic              out_valid_q;
  pix_out_t          out_data_q, res;
  logic [X_W-1:0]    x;
  logic [QP_W-1:0]   quot;
  logic [CHAN_W-1:0] level;
  logic [2:0]        lit;

  // whole back pipe moves when the output register frees up
  assign adv   = !out_valid_q || out_ready_i;
  assign pop_o = adv && !empty_i;

  always_comb begin
    unique case (data_i.wt)
      W_FULL:   gw = GW_W'(gain_i) * GW_W'(25);
      W_GAP:    gw = GW_W'(gain_i) * GW_W'(5);
      W_CORNER: gw = GW_W'(gain_i);
      default:  gw = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      b_valid_q   <= !empty_i;
      out_valid_q <= b_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      b_prod_q    <= PROD_W'(data_i.value) * PROD_W'(gw) + ROUND_BIAS;
      b_sel_q     <= data_i.sel;
      b_alpha_q   <= data_i.alpha;
      b_row_end_q <= data_i.row_end;
    end
    if (adv && b_valid_q) begin
      out_data_q <= res;
    end
  end

  // divide by 256 with a shift, then by 25 through a reciprocal
  assign x    = b_prod_q[PROD_W-1:SCALE_SHIFT];
  assign quot = QP_W'(x[QX_W-1:0]) * QP_W'(RECIP_25);
  assign level = (x >= SAT_LIMIT) ? CHAN_MAX : quot[RECIP_SHIFT +: CHAN_W];

  always_comb begin
    res.red_out     = '0;
    res.green_out   = '0;
    res.blue_out    = '0;
    res.alpha_out   = b_alpha_q;
    res.row_end_out = b_row_end_q;
    unique case (b_sel_q)
      CH_RED:   res.red_out   = level;
      CH_GREEN: res.green_out = level;
      CH_BLUE:  res.blue_out  = level;
      default:  res.red_out   = '0;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  assign lit = {out_data_q.red_out != '0, out_data_q.green_out != '0,
                out_data_q.blue_out != '0};

  `ASSERT_CLK(a_one_channel_lit, out_valid_q |-> ($countones(lit) <= 1), "more than one subpixel lit")

endmodule

FILE: hw/rtl/lcd_subpixel_mosaic_filter.sv
// ----------------------------------------------------------------------------
// lcd_subpixel_mosaic_filter
// pixelating mosaic with an rgb subpixel mask and brightness gain
// ----------------------------------------------------------------------------
// Takes one pixel per clock while the queue has room and gives one result per
// pixel, in order; a result passes the front stage register, the queue and
// the back product and output registers. The rate is set by the single port
// sample store in the front (one write or one read per pixel) and the two stage
// multiply path in the back; a four entry queue between them lets either side
// stall alone. The sample store needs no clearing after reset. Write cell_size
// and gain only while no transaction is in flight.
module lcd_subpixel_mosaic_filter (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  lsmf_pkg::pix_in_t           in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output lsmf_pkg::pix_out_t          out_data_o,
  input  logic                        cfg_we_i,
  input  logic                        cfg_idx_i,
  input  logic [lsmf_pkg::CFG_W-1:0]  cfg_data_i
);
  import lsmf_pkg::*;

  logic [CELL_W-1:0] cell_size_q, cell_size_d;
  logic [GAIN_W-1:0] gain_q, gain_d;
  logic              push, full, pop, empty;
  q_entry_t          push_data, pop_data;

  always_comb begin
    cell_size_d = cell_size_q;
    gain_d      = gain_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_CELL_SIZE: cell_size_d = cfg_data_i[CELL_W-1:0];
        CFG_GAIN:      gain_d      = cfg_data_i[GAIN_W-1:0];
        default:       gain_d      = gain_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_size_q <= CELL_SIZE_RESET;
      gain_q      <= GAIN_RESET;
    end else begin
      cell_size_q <= cell_size_d;
      gain_q      <= gain_d;
    end
  end

  lsmf_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cell_size_i(cell_size_q),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .push_o     (push),
    .full_i     (full),
    .push_data_o(push_data)
  );

  lsmf_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (push_data),
    .full_o (full),
    .pop_i  (pop),
    .empty_o(empty),
    .data_o (pop_data)
  );

  lsmf_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .gain_i     (gain_q),
    .pop_o      (pop),
    .empty_i    (empty),
    .data_i     (pop_data),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

endmodule
